// ----- design/hcte_pkg.sv -----
package hcte_pkg;

    // Command codes carried in the cmd field of an input word.
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_ENCODE = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    // Input word.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  symbol;
        logic [31:0] code_word;
        logic [5:0]  code_len;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       stream_end;
        logic       missing_code;
    } out_word_t;

    // Write side of the code table.
    typedef struct packed {
        logic        en;
        logic [7:0]  addr;
        logic [31:0] code;
        logic [5:0]  len;
    } tbl_wr_t;

    // Registered read data of the code table.
    typedef struct packed {
        logic [31:0] code;
        logic [5:0]  len;
        logic        loaded;
    } tbl_rd_t;

endpackage

// ----- design/huffman_code_table_encoder_core.sv -----
// An item passes the lookup stage, the emit stage and the output register, in that order.
// One result word per cycle while rsp_stall is low; an item yields up to
// (MAX_CODE_LEN + 7) / 8 bytes, sent one at a time through the single byte output port of the packer.
// Load, zero-length and empty-flush items yield no result word.
// Reset clears the pipeline, the bit packer and all table loaded flags at once;
// table contents need no clearing pass.
module huffman_code_table_encoder_core
    import hcte_pkg::*;
#(
    parameter int MAX_CODE_LEN = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  in_word_t  req_word,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output out_word_t rsp_word
);

    localparam int ACC_W   = MAX_CODE_LEN + 7;
    localparam int CW      = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
    localparam int SH_W    = $clog2(ACC_W + 1);
    localparam int MAX_RES = ACC_W / 8;
    localparam int NB_W    = $clog2(MAX_RES + 1);

    logic            accept;
    logic            is_load;
    logic            is_encode;
    logic            is_flush;
    logic [5:0]      len_sat;
    logic [63:0]     code_mask;
    tbl_wr_t         tbl_wr;
    tbl_rd_t         tbl_rd;

    logic            a_valid_reg;
    logic            a_flush_reg;
    logic            a_move;

    logic [6:0]      pend_reg;
    logic [6:0]      pend_next;
    logic [2:0]      pcnt_reg;
    logic [2:0]      pcnt_next;

    logic [NB_W-1:0]  b_cnt_reg;
    logic [NB_W-1:0]  b_cnt_next;
    logic [ACC_W-1:0] b_acc_reg;
    logic [ACC_W-1:0] b_acc_next;
    logic             b_end_reg;
    logic             b_end_next;
    logic             b_miss_reg;
    logic             b_miss_next;
    logic             b_valid;
    logic             b_emit;
    logic             b_free;

    logic             out_load;
    logic             rsp_valid_reg;
    out_word_t        rsp_word_reg;

    logic [SH_W-1:0]  total;
    logic [SH_W-1:0]  shamt;
    logic [SH_W-1:0]  byte_shamt;
    logic [ACC_W-1:0] code_ext;
    logic [ACC_W-1:0] pend_ext;
    logic [ACC_W-1:0] acc_l;
    logic [ACC_W-1:0] rem;

    // Input decode and handshake.
    assign is_load   = (req_word.cmd == CMD_LOAD);
    assign is_encode = (req_word.cmd == CMD_ENCODE);
    assign is_flush  = (req_word.cmd == CMD_FLUSH);
    assign req_stall = a_valid_reg && !a_move;
    assign accept    = req_valid && !req_stall;

    // Loads saturate the length and drop code bits above it before storage.
    assign len_sat   = (req_word.code_len > 6'(MAX_CODE_LEN)) ? 6'(MAX_CODE_LEN)
                                                             : req_word.code_len;
    assign code_mask = ~({64{1'b1}} << len_sat);

    assign tbl_wr.en   = accept && is_load;
    assign tbl_wr.addr = req_word.symbol;
    assign tbl_wr.code = req_word.code_word & code_mask[31:0];
    assign tbl_wr.len  = len_sat;

    hcte_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (tbl_wr),
        .rd_en   (accept),
        .rd_addr (req_word.symbol),
        .rd      (tbl_rd)
    );

    // Lookup stage holds encode and flush words while the table read completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            a_flush_reg <= 1'b0;
        end
        else if (accept)
        begin
            a_valid_reg <= is_encode || is_flush;
            a_flush_reg <= is_flush;
        end
        else if (a_move)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    // Emit stage and output register handshake.
    assign b_valid  = (b_cnt_reg != '0);
    assign out_load = !rsp_valid_reg || !rsp_stall;
    assign b_emit   = b_valid && out_load;
    assign b_free   = !b_valid || (b_emit && (b_cnt_reg == NB_W'(1)));
    assign a_move   = a_valid_reg && b_free;

    // Pack the pending bits and the code left-aligned in one accumulator.
    // Pending bits are kept left-aligned with zeros below the valid ones.
    always_comb
    begin
        total      = SH_W'(pcnt_reg) + SH_W'(tbl_rd.len);
        shamt      = SH_W'(ACC_W) - total;
        byte_shamt = {total[SH_W-1:3], 3'b000};
        code_ext   = {{(ACC_W - CW){1'b0}}, tbl_rd.code[CW-1:0]};
        pend_ext   = {pend_reg, {(ACC_W - 7){1'b0}}};
        acc_l      = pend_ext | (code_ext << shamt);
        rem        = acc_l << byte_shamt;
    end

    // Next packer and emit-stage contents for the word leaving the lookup stage.
    always_comb
    begin
        pend_next   = pend_reg;
        pcnt_next   = pcnt_reg;
        b_cnt_next  = '0;
        b_acc_next  = pend_ext;
        b_end_next  = 1'b0;
        b_miss_next = 1'b0;
        priority if (a_flush_reg)
        begin
            // Flush sends the padded partial byte, if any, and empties the packer.
            b_cnt_next = (pcnt_reg != 3'd0) ? NB_W'(1) : '0;
            b_end_next = 1'b1;
            pend_next  = '0;
            pcnt_next  = '0;
        end
        else if (!tbl_rd.loaded)
        begin
            // Symbol without a loaded code gives a single flagged zero byte.
            b_cnt_next  = NB_W'(1);
            b_acc_next  = '0;
            b_miss_next = 1'b1;
        end
        else
        begin
            b_cnt_next = NB_W'(total >> 3);
            b_acc_next = acc_l;
            pend_next  = rem[ACC_W-1 -: 7];
            pcnt_next  = total[2:0];
        end
    end

    // Bit packer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            pcnt_reg <= '0;
        end
        else if (a_move)
        begin
            pend_reg <= pend_next;
            pcnt_reg <= pcnt_next;
        end
    end

    // Emit stage: shifts out one byte per cycle from the top of the accumulator unless stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_cnt_reg <= '0;
        end
        else if (a_move)
        begin
            b_cnt_reg <= b_cnt_next;
        end
        else if (b_emit)
        begin
            b_cnt_reg <= b_cnt_reg - NB_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            b_acc_reg  <= b_acc_next;
            b_end_reg  <= b_end_next;
            b_miss_reg <= b_miss_next;
        end
        else if (b_emit)
        begin
            b_acc_reg <= b_acc_reg << 8;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            rsp_valid_reg <= b_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_emit)
        begin
            rsp_word_reg.out_byte     <= b_acc_reg[ACC_W-1 -: 8];
            rsp_word_reg.last_of_run  <= (b_cnt_reg == NB_W'(1));
            rsp_word_reg.stream_end   <= b_end_reg;
            rsp_word_reg.missing_code <= b_miss_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule

// ----- design/hcte_table.sv -----
module hcte_table
    import hcte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  tbl_wr_t    wr,
    input  logic       rd_en,
    input  logic [7:0] rd_addr,
    output tbl_rd_t    rd
);

    logic [31:0]  code_mem [256];
    logic [5:0]   len_mem  [256];
    logic [255:0] loaded_reg;
    logic [31:0]  rd_code_reg;
    logic [5:0]   rd_len_reg;
    logic         rd_loaded_reg;

    // Code and length storage; contents are undefined until loaded.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            code_mem[wr.addr] <= wr.code;
            len_mem[wr.addr]  <= wr.len;
        end
        if (rd_en)
        begin
            rd_code_reg <= code_mem[rd_addr];
            rd_len_reg  <= len_mem[rd_addr];
        end
    end

    // Per-entry loaded flags, cleared at reset, and their registered read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg    <= '0;
            rd_loaded_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                loaded_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_loaded_reg <= loaded_reg[rd_addr];
            end
        end
    end

    assign rd = {rd_code_reg, rd_len_reg, rd_loaded_reg};

endmodule
